/* hdl/fsdm_pkg.sv */
`timescale 1ns / 1ps

package fsdm_pkg;

    localparam int DEFAULT_WIDTH = 32;
    localparam int STATUS_W      = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic dvd_neg;
        logic dsr_neg;
        logic div_zero;
        logic overflow;
    } t_fsdm_flags;

endpackage

/* hdl/floored_signed_divide_modulo_unit.sv */
// A request passes the input stage, the division stage chain and the output stage before its result is valid.
// Throughput: one request per cycle while the result is not stalled; one restoring-division bit per pipeline stage.
// A stalled result freezes the whole pipeline and stalls the request side.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps

module floored_signed_divide_modulo_unit import fsdm_pkg::*; #(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [WIDTH-1:0]  i_dividend,
    input  logic signed [WIDTH-1:0]  i_divisor,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [WIDTH-1:0]  o_quotient,
    output logic signed [WIDTH-1:0]  o_remainder,
    output logic [STATUS_W-1:0]      o_status
);

    localparam logic [WIDTH-1:0] MIN_VAL = {1'b1, {(WIDTH-1){1'b0}}};

    logic en;

    // input stage
    logic              r_in_valid;
    t_fsdm_flags       r_in_flags;
    logic [WIDTH-1:0]  r_in_dvd_mag;
    logic [WIDTH-1:0]  r_in_dsr_mag;
    t_fsdm_flags       n_in_flags;
    logic [WIDTH-1:0]  n_in_dvd_mag;
    logic [WIDTH-1:0]  n_in_dsr_mag;

    // division chain
    logic              v_chain   [0:WIDTH];
    t_fsdm_flags       f_chain   [0:WIDTH];
    logic [WIDTH-1:0]  rem_chain [0:WIDTH];
    logic [WIDTH-1:0]  quo_chain [0:WIDTH];
    logic [WIDTH-1:0]  dsr_chain [0:WIDTH];

    // output stage
    logic                  r_out_valid;
    logic [WIDTH-1:0]      r_quotient;
    logic [WIDTH-1:0]      r_remainder;
    logic [STATUS_W-1:0]   r_status;
    logic [WIDTH-1:0]      n_quotient;
    logic [WIDTH-1:0]      n_remainder;
    logic [STATUS_W-1:0]   n_status;

    logic [WIDTH+1:0]      valid_vec;

    assign en      = ~(r_out_valid & i_stall);
    assign o_stall = ~en;

    always_comb begin
        n_in_flags.dvd_neg  = i_dividend[WIDTH-1];
        n_in_flags.dsr_neg  = i_divisor[WIDTH-1];
        n_in_flags.div_zero = (i_divisor == '0);
        n_in_flags.overflow = (i_dividend == MIN_VAL) && (i_divisor == '1);
        n_in_dvd_mag = i_dividend[WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
        n_in_dsr_mag = i_divisor[WIDTH-1]  ? (~i_divisor + 1'b1)  : i_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_flags   <= n_in_flags;
            r_in_dvd_mag <= n_in_dvd_mag;
            r_in_dsr_mag <= n_in_dsr_mag;
        end
    end

    assign v_chain[0]   = r_in_valid;
    assign f_chain[0]   = r_in_flags;
    assign rem_chain[0] = '0;
    assign quo_chain[0] = r_in_dvd_mag;
    assign dsr_chain[0] = r_in_dsr_mag;

    for (genvar k = 0; k < WIDTH; k++) begin : g_stage
        fsdm_div_stage #(
            .WIDTH (WIDTH)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_chain[k]),
            .i_flags (f_chain[k]),
            .i_rem   (rem_chain[k]),
            .i_quo   (quo_chain[k]),
            .i_dsr   (dsr_chain[k]),
            .o_valid (v_chain[k+1]),
            .o_flags (f_chain[k+1]),
            .o_rem   (rem_chain[k+1]),
            .o_quo   (quo_chain[k+1]),
            .o_dsr   (dsr_chain[k+1])
        );
    end

    // divide-by-zero and overflow status, floor correction and sign restore
    always_comb begin
        n_status = STATUS_OK;
        if (f_chain[WIDTH].div_zero) begin
            n_quotient  = '0;
            n_remainder = '0;
            n_status    = STATUS_DIV_ZERO;
        end else if (f_chain[WIDTH].dvd_neg == f_chain[WIDTH].dsr_neg) begin
            n_quotient  = quo_chain[WIDTH];
            n_remainder = f_chain[WIDTH].dsr_neg ? (~rem_chain[WIDTH] + 1'b1)
                                                 : rem_chain[WIDTH];
            if (f_chain[WIDTH].overflow) begin
                n_status = STATUS_OVERFLOW;
            end
        end else if (rem_chain[WIDTH] == '0) begin
            n_quotient  = ~quo_chain[WIDTH] + 1'b1;
            n_remainder = '0;
        end else begin
            n_quotient  = ~quo_chain[WIDTH];
            n_remainder = dsr_chain[WIDTH] - rem_chain[WIDTH];
            if (f_chain[WIDTH].dsr_neg) begin
                n_remainder = rem_chain[WIDTH] - dsr_chain[WIDTH];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= v_chain[WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_quotient  <= n_quotient;
            r_remainder <= n_remainder;
            r_status    <= n_status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_quotient  = r_quotient;
    assign o_remainder = r_remainder;
    assign o_status    = r_status;

    always_comb begin
        valid_vec[WIDTH+1] = r_out_valid;
        for (int k = 0; k <= WIDTH; k++) begin
            valid_vec[k] = v_chain[k];
        end
    end

    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> $stable(valid_vec))
        else $error("pipeline valid bits moved during stall");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STATUS_DIV_ZERO) |-> (r_quotient == '0 && r_remainder == '0))
        else $error("divide by zero result not cleared");

    a_overflow_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STATUS_OVERFLOW) |-> (r_quotient == MIN_VAL && r_remainder == '0))
        else $error("overflow result wrong");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in_valid)
        else $error("accepted request lost at input stage");

endmodule

/* hdl/fsdm_div_stage.sv */
`timescale 1ns / 1ps

module fsdm_div_stage import fsdm_pkg::*; #(
    parameter int WIDTH = DEFAULT_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_fsdm_flags       i_flags,
    input  logic [WIDTH-1:0]  i_rem,
    input  logic [WIDTH-1:0]  i_quo,
    input  logic [WIDTH-1:0]  i_dsr,
    output logic              o_valid,
    output t_fsdm_flags       o_flags,
    output logic [WIDTH-1:0]  o_rem,
    output logic [WIDTH-1:0]  o_quo,
    output logic [WIDTH-1:0]  o_dsr
);

    logic              r_valid;
    t_fsdm_flags       r_flags;
    logic [WIDTH-1:0]  r_rem;
    logic [WIDTH-1:0]  r_quo;
    logic [WIDTH-1:0]  r_dsr;

    logic [WIDTH:0]    trial;
    logic              q_bit;
    logic [WIDTH-1:0]  n_rem;
    logic [WIDTH-1:0]  n_quo;

    always_comb begin
        trial = {i_rem, i_quo[WIDTH-1]} - {1'b0, i_dsr};
        q_bit = ~trial[WIDTH];
        n_rem = q_bit ? trial[WIDTH-1:0] : {i_rem[WIDTH-2:0], i_quo[WIDTH-1]};
        n_quo = {i_quo[WIDTH-2:0], q_bit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= i_flags;
            r_rem   <= n_rem;
            r_quo   <= n_quo;
            r_dsr   <= i_dsr;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_dsr   = r_dsr;

endmodule
